FILE: rtl/rsc_pkg.sv
// Shared types and constants for the resource safety check block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package rsc_pkg;

  localparam int DEF_MAX_PROCS = 16;
  localparam int DEF_MAX_RES   = 8;
  localparam int RESULT_LIMIT  = 16;

  localparam int MODE_W    = 2;
  localparam int PIDX_W    = 4;
  localparam int RIDX_W    = 3;
  localparam int VAL_W     = 16;
  localparam int NEED_W    = 17;
  localparam int WORK_W    = 24;
  localparam int ID_W      = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 5;
  localparam int PCOUNT_W  = 5;
  localparam int RCOUNT_W  = 4;

  localparam logic [MODE_W-1:0] MODE_LOAD_CELL  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_AVAIL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RUN        = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESOURCE_COUNT = 1'b1;

  localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 5'd16;
  localparam logic [RCOUNT_W-1:0] RCOUNT_RESET = 4'd8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_PROC,
    ST_FETCH,
    ST_CHECK,
    ST_REL_FETCH,
    ST_REL_ADD,
    ST_NEXT,
    ST_EMIT,
    ST_UNSAFE
  } state_t;

  typedef struct packed {
    logic load_cell;
    logic load_avail;
    logic init;
    logic j_clear;
    logic j_inc;
    logic p_inc;
    logic pass_restart;
    logic finish;
    logic release_alloc;
    logic k_clear;
    logic k_inc;
    logic sel_unsafe;
  } rsc_cmd_t;

  typedef struct packed {
    logic proc_finished;
    logic elem_fail;
    logic j_last;
    logic p_last;
    logic all_done;
    logic progress;
    logic k_last;
  } rsc_sts_t;

endpackage

FILE: rtl/rsc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module rsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/rsc_ctrl.sv
// Controller state machine of the safety check: handshakes and pass sequencing.
// Depends on rsc_pkg; drives the datapath through rsc_cmd_t and reads rsc_sts_t.
`timescale 1ns / 1ps

module rsc_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rsc_pkg::MODE_W-1:0]    in_mode,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_unsafe,
  output logic                          out_last,
  output rsc_pkg::rsc_cmd_t             cmd,
  input  rsc_pkg::rsc_sts_t             sts
);

  rsc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rsc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rsc_pkg::ST_IDLE: begin
        if (in_valid && in_mode == rsc_pkg::MODE_RUN) begin
          state_nxt = rsc_pkg::ST_INIT;
        end
      end
      rsc_pkg::ST_INIT:      state_nxt = rsc_pkg::ST_PROC;
      rsc_pkg::ST_PROC: begin
        state_nxt = sts.proc_finished ? rsc_pkg::ST_NEXT : rsc_pkg::ST_FETCH;
      end
      rsc_pkg::ST_FETCH:     state_nxt = rsc_pkg::ST_CHECK;
      rsc_pkg::ST_CHECK: begin
        priority if (sts.elem_fail) begin
          state_nxt = rsc_pkg::ST_NEXT;
        end else if (sts.j_last) begin
          state_nxt = rsc_pkg::ST_REL_FETCH;
        end else begin
          state_nxt = rsc_pkg::ST_FETCH;
        end
      end
      rsc_pkg::ST_REL_FETCH: state_nxt = rsc_pkg::ST_REL_ADD;
      rsc_pkg::ST_REL_ADD: begin
        state_nxt = sts.j_last ? rsc_pkg::ST_NEXT : rsc_pkg::ST_REL_FETCH;
      end
      rsc_pkg::ST_NEXT: begin
        priority if (!sts.p_last) begin
          state_nxt = rsc_pkg::ST_PROC;
        end else if (sts.all_done) begin
          state_nxt = rsc_pkg::ST_EMIT;
        end else if (!sts.progress) begin
          state_nxt = rsc_pkg::ST_UNSAFE;
        end else begin
          state_nxt = rsc_pkg::ST_PROC;
        end
      end
      rsc_pkg::ST_EMIT: begin
        if (out_ready && sts.k_last) begin
          state_nxt = rsc_pkg::ST_IDLE;
        end
      end
      rsc_pkg::ST_UNSAFE: begin
        if (out_ready) begin
          state_nxt = rsc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    out_unsafe = 1'b0;
    out_last   = 1'b0;
    unique case (state_r)
      rsc_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.load_cell  = in_valid && in_mode == rsc_pkg::MODE_LOAD_CELL;
        cmd.load_avail = in_valid && in_mode == rsc_pkg::MODE_LOAD_AVAIL;
      end
      rsc_pkg::ST_INIT: cmd.init = 1'b1;
      rsc_pkg::ST_PROC: cmd.j_clear = 1'b1;
      rsc_pkg::ST_FETCH: ;
      rsc_pkg::ST_CHECK: begin
        if (!sts.elem_fail) begin
          cmd.finish = sts.j_last;
          cmd.j_inc  = !sts.j_last;
        end
      end
      rsc_pkg::ST_REL_FETCH: ;
      rsc_pkg::ST_REL_ADD: begin
        cmd.release_alloc = 1'b1;
        cmd.j_inc         = !sts.j_last;
      end
      rsc_pkg::ST_NEXT: begin
        cmd.p_inc        = !sts.p_last;
        cmd.k_clear      = sts.p_last && sts.all_done;
        cmd.pass_restart = sts.p_last && !sts.all_done && sts.progress;
      end
      rsc_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        out_last  = sts.k_last;
        cmd.k_inc = out_ready && !sts.k_last;
      end
      rsc_pkg::ST_UNSAFE: begin
        out_valid      = 1'b1;
        out_unsafe     = 1'b1;
        out_last       = 1'b1;
        cmd.sel_unsafe = 1'b1;
      end
      default: ;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted while a result is pending");

  a_check_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rsc_pkg::ST_CHECK |-> $past(state_r) == rsc_pkg::ST_FETCH)
    else $error("compare without a preceding table read");

  a_emit_complete: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rsc_pkg::ST_EMIT |-> sts.all_done)
    else $error("safe order emitted before every process finished");

  a_unsafe_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rsc_pkg::ST_UNSAFE && $past(state_r) != rsc_pkg::ST_UNSAFE)
      |-> ($past(state_r) == rsc_pkg::ST_NEXT && !$past(sts.progress)))
    else $error("unsafe result without a pass that made no progress");

endmodule

FILE: rtl/rsc_datapath.sv
// Datapath of the safety check: count registers, cell table, working set,
// finished flags and safe order. Depends on rsc_pkg and rsc_ram.
`timescale 1ns / 1ps

module rsc_datapath #(
  parameter int MAX_PROCS = rsc_pkg::DEF_MAX_PROCS,
  parameter int MAX_RES   = rsc_pkg::DEF_MAX_RES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsc_pkg::CFG_W-1:0]      cfg_data,
  input  logic [rsc_pkg::PIDX_W-1:0]     in_proc_index,
  input  logic [rsc_pkg::RIDX_W-1:0]     in_res_index,
  input  logic [rsc_pkg::VAL_W-1:0]      in_alloc_value,
  input  logic [rsc_pkg::VAL_W-1:0]      in_max_value,
  input  logic [rsc_pkg::VAL_W-1:0]      in_avail_value,
  input  rsc_pkg::rsc_cmd_t              cmd,
  output rsc_pkg::rsc_sts_t              sts,
  output logic [rsc_pkg::ID_W-1:0]       out_process_id
);

  localparam int PW    = MAX_PROCS > 1 ? $clog2(MAX_PROCS) : 1;
  localparam int RW    = MAX_RES > 1 ? $clog2(MAX_RES) : 1;
  localparam int PLIM  = MAX_PROCS < rsc_pkg::RESULT_LIMIT ? MAX_PROCS
                                                           : rsc_pkg::RESULT_LIMIT;
  localparam int PIW   = PLIM > 1 ? $clog2(PLIM) : 1;
  localparam int PLW   = $clog2(PLIM + 1);
  localparam int NRW   = $clog2(MAX_RES + 1);
  localparam int PXW   = PW > rsc_pkg::PIDX_W ? PW : rsc_pkg::PIDX_W;
  localparam int RXW   = RW > rsc_pkg::RIDX_W ? RW : rsc_pkg::RIDX_W;
  localparam int AW    = PW + RW;
  localparam int CELL_W = rsc_pkg::NEED_W + rsc_pkg::VAL_W;

  logic [rsc_pkg::PCOUNT_W-1:0] process_count_r, process_count_nxt;
  logic [rsc_pkg::RCOUNT_W-1:0] resource_count_r, resource_count_nxt;
  logic [PIW-1:0]               p_r, p_nxt;
  logic [RW-1:0]                j_r, j_nxt;
  logic [PIW-1:0]               k_r, k_nxt;
  logic [PLW-1:0]               count_r, count_nxt;
  logic [PLW-1:0]               np_r, np_nxt;
  logic [NRW-1:0]               nr_r, nr_nxt;
  logic                         progress_r, progress_nxt;
  logic [PLIM-1:0]              finished_r;
  logic [rsc_pkg::ID_W-1:0]     safe_order_r [PLIM];
  logic [rsc_pkg::VAL_W-1:0]    avail_loaded_r [MAX_RES];
  logic [rsc_pkg::WORK_W-1:0]   avail_work_r [MAX_RES];

  logic [PXW-1:0]               pi_wide;
  logic [RXW-1:0]               ri_wide;
  logic [PW-1:0]                pi_idx;
  logic [RW-1:0]                ri_idx;
  logic                         pi_ok, ri_ok;
  logic                         cell_we;
  logic [rsc_pkg::NEED_W-1:0]   need_in;
  logic [CELL_W-1:0]            cell_wdata, cell_rdata;
  logic [AW-1:0]                cell_waddr, cell_raddr;
  logic [rsc_pkg::NEED_W-1:0]   rd_need;
  logic [rsc_pkg::VAL_W-1:0]    rd_alloc;

  assign pi_wide = PXW'(in_proc_index);
  assign ri_wide = RXW'(in_res_index);
  assign pi_idx  = pi_wide[PW-1:0];
  assign ri_idx  = ri_wide[RW-1:0];
  assign pi_ok   = 32'(in_proc_index) < MAX_PROCS;
  assign ri_ok   = 32'(in_res_index) < MAX_RES;

  // A negative need marks a cell whose maximum lies below its allocation.
  assign need_in    = {1'b0, in_max_value} - {1'b0, in_alloc_value};
  assign cell_we    = cmd.load_cell && pi_ok && ri_ok;
  assign cell_wdata = {need_in, in_alloc_value};
  assign cell_waddr = {pi_idx, ri_idx};
  assign cell_raddr = {PW'(p_r), j_r};
  assign rd_need    = cell_rdata[CELL_W-1:rsc_pkg::VAL_W];
  assign rd_alloc   = cell_rdata[rsc_pkg::VAL_W-1:0];

  rsc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (1 << AW)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  always_comb begin
    process_count_nxt  = process_count_r;
    resource_count_nxt = resource_count_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rsc_pkg::CFG_PROCESS_COUNT:  process_count_nxt = cfg_data;
        rsc_pkg::CFG_RESOURCE_COUNT: resource_count_nxt = cfg_data[rsc_pkg::RCOUNT_W-1:0];
        default: ;
      endcase
    end

    np_nxt = np_r;
    nr_nxt = nr_r;
    if (cmd.init) begin
      priority if (process_count_r == '0) begin
        np_nxt = PLW'(1);
      end else if (32'(process_count_r) > PLIM) begin
        np_nxt = PLW'(PLIM);
      end else begin
        np_nxt = PLW'(process_count_r);
      end
      priority if (resource_count_r == '0) begin
        nr_nxt = NRW'(1);
      end else if (32'(resource_count_r) > MAX_RES) begin
        nr_nxt = NRW'(MAX_RES);
      end else begin
        nr_nxt = NRW'(resource_count_r);
      end
    end

    p_nxt = p_r;
    if (cmd.init || cmd.pass_restart) begin
      p_nxt = '0;
    end else if (cmd.p_inc) begin
      p_nxt = p_r + 1'b1;
    end

    j_nxt = j_r;
    if (cmd.j_clear || cmd.finish) begin
      j_nxt = '0;
    end else if (cmd.j_inc) begin
      j_nxt = j_r + 1'b1;
    end

    k_nxt = k_r;
    if (cmd.k_clear) begin
      k_nxt = '0;
    end else if (cmd.k_inc) begin
      k_nxt = k_r + 1'b1;
    end

    count_nxt = count_r;
    if (cmd.init) begin
      count_nxt = '0;
    end else if (cmd.finish) begin
      count_nxt = count_r + 1'b1;
    end

    progress_nxt = progress_r;
    if (cmd.init || cmd.pass_restart) begin
      progress_nxt = 1'b0;
    end else if (cmd.finish) begin
      progress_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      process_count_r  <= rsc_pkg::PCOUNT_RESET;
      resource_count_r <= rsc_pkg::RCOUNT_RESET;
      count_r          <= '0;
      progress_r       <= 1'b0;
      finished_r       <= '0;
      p_r              <= '0;
      j_r              <= '0;
      k_r              <= '0;
      np_r             <= PLW'(1);
      nr_r             <= NRW'(1);
    end else begin
      process_count_r  <= process_count_nxt;
      resource_count_r <= resource_count_nxt;
      count_r          <= count_nxt;
      progress_r       <= progress_nxt;
      p_r              <= p_nxt;
      j_r              <= j_nxt;
      k_r              <= k_nxt;
      np_r             <= np_nxt;
      nr_r             <= nr_nxt;
      if (cmd.init) begin
        finished_r <= '0;
      end else if (cmd.finish) begin
        finished_r[p_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MAX_RES; r++) begin
        avail_work_r[r] <= '0;
      end
    end else if (cmd.init) begin
      for (int r = 0; r < MAX_RES; r++) begin
        avail_work_r[r] <= rsc_pkg::WORK_W'(avail_loaded_r[r]);
      end
    end else if (cmd.release_alloc) begin
      avail_work_r[j_r] <= avail_work_r[j_r] + rsc_pkg::WORK_W'(rd_alloc);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_avail && ri_ok) begin
      avail_loaded_r[ri_idx] <= in_avail_value;
    end
    if (cmd.finish) begin
      safe_order_r[count_r[PIW-1:0]] <= rsc_pkg::ID_W'(p_r);
    end
  end

  assign sts.proc_finished = finished_r[p_r];
  assign sts.elem_fail     = !rd_need[rsc_pkg::NEED_W-1] &&
                             (rsc_pkg::WORK_W'(rd_need[rsc_pkg::VAL_W-1:0]) > avail_work_r[j_r]);
  assign sts.j_last        = 32'(j_r) + 1 == 32'(nr_r);
  assign sts.p_last        = 32'(p_r) + 1 == 32'(np_r);
  assign sts.all_done      = count_r == np_r;
  assign sts.progress      = progress_r;
  assign sts.k_last        = 32'(k_r) + 1 == 32'(np_r);

  assign out_process_id = cmd.sel_unsafe ? '0 : safe_order_r[k_r];

endmodule

FILE: rtl/resource_safety_check.sv
// Top level of the resource safety check: joins the controller and the datapath.
// Depends on rsc_pkg, rsc_ctrl, rsc_datapath and rsc_ram.
`timescale 1ns / 1ps

// Usage. Input beats carry a mode. Mode 0 stores the allocation and maximum of
// one process/resource cell, mode 1 stores one available count, mode 2 runs the
// safety check and mode 3 is dropped. Loads and dropped beats produce no result
// and keep the block idle, so they stream at one beat per cycle between runs.
// A run produces either np result beats giving the safe order, with last set on
// the final one, or a single beat with unsafe and last set. np and nr are the
// process_count and resource_count registers clamped to their legal ranges.
// A run is processed one at a time: in_ready stays low from the run beat until
// its final result beat is taken. The scan reads one cell at a time from the
// registered-read cell table, with a fetch state ahead of each check or
// release state that uses the cell. Results are held stable while out_ready is
// low; the block waits without limit. Configuration writes are registered and
// must be made while idle. Reset sets process_count to 16 and resource_count
// to 8 and returns to idle; cells and available counts must be loaded before
// they are used in a run.
module resource_safety_check #(
  parameter int MAX_PROCS = rsc_pkg::DEF_MAX_PROCS,
  parameter int MAX_RES   = rsc_pkg::DEF_MAX_RES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsc_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rsc_pkg::MODE_W-1:0]     in_mode,
  input  logic [rsc_pkg::PIDX_W-1:0]     in_proc_index,
  input  logic [rsc_pkg::RIDX_W-1:0]     in_res_index,
  input  logic [rsc_pkg::VAL_W-1:0]      in_alloc_value,
  input  logic [rsc_pkg::VAL_W-1:0]      in_max_value,
  input  logic [rsc_pkg::VAL_W-1:0]      in_avail_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rsc_pkg::ID_W-1:0]       out_process_id,
  output logic                           out_unsafe,
  output logic                           out_last
);

  rsc_pkg::rsc_cmd_t cmd;
  rsc_pkg::rsc_sts_t sts;

  rsc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_mode    (in_mode),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_unsafe (out_unsafe),
    .out_last   (out_last),
    .cmd        (cmd),
    .sts        (sts)
  );

  rsc_datapath #(
    .MAX_PROCS (MAX_PROCS),
    .MAX_RES   (MAX_RES)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_proc_index  (in_proc_index),
    .in_res_index   (in_res_index),
    .in_alloc_value (in_alloc_value),
    .in_max_value   (in_max_value),
    .in_avail_value (in_avail_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_process_id (out_process_id)
  );

endmodule
